### design/crx_pkg.sv
// Shared types and constants for the checksummed frame receiver.
// Used by crx_front, crx_back and checksummed_frame_receiver; no dependencies.
`default_nettype none

package crx_pkg;

  localparam int SLOTS       = 4;
  localparam int MAX_FRAME   = 66;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STORE_DEPTH = SLOTS * MAX_FRAME;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH = 2;

  localparam int OP_W        = 2;
  localparam int SEL_W       = 2;
  localparam int IDX_W       = 7;
  localparam int LEN_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int ID_W        = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_BAD_SUM     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACK_MATCH   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACK_IGNORED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STORED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_DATA   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_SEQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE = 2'd2;

  typedef enum logic [1:0] {
    K_BYTE,
    K_RELEASE,
    K_READ
  } crx_kind_e;

  typedef struct packed {
    crx_kind_e        kind;
    logic [7:0]       data;
    logic             last;
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
  } crx_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    slot;
    logic [LEN_W-1:0]    length;
  } crx_res_t;

  typedef struct packed {
    logic [ID_W-1:0] own_id;
    logic [7:0]      exp_seq;
    logic [7:0]      ack_type;
  } crx_cfg_t;

endpackage

`default_nettype wire

### design/crx_front.sv
// Front end: accepts input words, classifies the operation and queues commands.
// Depends on crx_pkg.
`default_nettype none

module crx_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [crx_pkg::IN_TDATA_W-1:0] in_data_i,
  input  wire                            in_last_i,
  input  wire  [crx_pkg::OP_W-1:0]       in_op_i,
  output logic                           cmd_valid_o,
  output crx_pkg::crx_cmd_t              cmd_o,
  input  wire                            cmd_pop_i
);
  import crx_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  crx_cmd_t          queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  crx_cmd_t          dec_cmd;
  logic              dec_keep, push, pop;

  always_comb begin
    dec_cmd.data = in_data_i[7:0];
    dec_cmd.last = in_last_i;
    dec_cmd.sel  = in_data_i[8 +: SEL_W];
    dec_cmd.idx  = in_data_i[8 + SEL_W +: IDX_W];
    dec_keep     = 1'b1;
    unique case (in_op_i)
      OP_BYTE:    dec_cmd.kind = K_BYTE;
      OP_RELEASE: dec_cmd.kind = K_RELEASE;
      OP_READ:    dec_cmd.kind = K_READ;
      default: begin
        dec_cmd.kind = K_BYTE;
        dec_keep     = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_valid_i && in_ready_o && dec_keep;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_pop_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

### design/crx_back.sv
// Back end: runs frame checksum, header capture, slot store and consumer reads.
// Holds the frame memory and the output register. Depends on crx_pkg.
`default_nettype none

module crx_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire crx_pkg::crx_cfg_t          cfg_i,
  input  wire                             cmd_valid_i,
  input  wire crx_pkg::crx_cmd_t          cmd_i,
  output logic                            cmd_pop_o,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [crx_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic [crx_pkg::STATUS_W-1:0]    out_status_o
);
  import crx_pkg::*;

  logic [7:0]        store_mem [STORE_DEPTH];
  logic [7:0]        mem_rd_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_re;

  logic [SLOTS-1:0]  used_q, used_d;
  logic [LEN_W-1:0]  len_q [SLOTS];
  logic              len_we;

  logic [7:0]        xor_q, xor_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        type_q, type_d;
  logic [ID_W-1:0]   src_q, src_d;
  logic [7:0]        seq_q, seq_d;
  logic              tgt_valid_q, tgt_valid_d;
  logic [SLOT_W-1:0] tgt_q, tgt_d;
  logic              over_q, over_d;

  logic              p2_valid_q, p2_valid_d, p2_hit_q, p2_hit_d;
  crx_res_t          p2_res_q, p2_res_d;
  logic              out_valid_q;
  crx_res_t          out_res_q;
  logic [7:0]        out_rdata_q;

  logic              out_load, p2_free, pop, is_byte, is_release, is_read;
  logic              first, any_free, tv, in_range, sel_ok, rd_hit;
  logic [SLOT_W-1:0] free_idx, ts, sel_slot;
  logic [LEN_W-1:0]  rd_len;

  assign out_load  = !out_valid_q || out_ready_i;
  assign p2_free   = !p2_valid_q || out_load;
  assign cmd_pop_o = cmd_valid_i && p2_free;
  assign pop       = cmd_pop_o;

  assign is_byte    = pop && (cmd_i.kind == K_BYTE);
  assign is_release = pop && (cmd_i.kind == K_RELEASE);
  assign is_read    = pop && (cmd_i.kind == K_READ);

  assign sel_ok   = (int'(cmd_i.sel) < SLOTS);
  assign sel_slot = cmd_i.sel[SLOT_W-1:0];

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    first    = (cnt_q == '0) && !over_q;
    tv       = first ? any_free : tgt_valid_q;
    ts       = first ? free_idx : tgt_q;
    in_range = (cnt_q < LEN_W'(MAX_FRAME));
    rd_len   = sel_ok ? len_q[sel_slot] : '0;
    rd_hit   = sel_ok && (cmd_i.idx < rd_len) && (cmd_i.idx < IDX_W'(MAX_FRAME));

    xor_d       = xor_q;
    cnt_d       = cnt_q;
    type_d      = type_q;
    src_d       = src_q;
    seq_d       = seq_q;
    tgt_valid_d = tgt_valid_q;
    tgt_d       = tgt_q;
    over_d      = over_q;
    used_d      = used_q;
    len_we      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    p2_valid_d  = p2_valid_q;
    p2_res_d    = p2_res_q;
    p2_hit_d    = p2_hit_q;

    if (p2_free) begin
      p2_valid_d = 1'b0;
    end

    if (is_byte) begin
      xor_d       = xor_q ^ cmd_i.data;
      tgt_valid_d = tv;
      tgt_d       = ts;
      mem_addr    = ADDR_W'(ts) * ADDR_W'(MAX_FRAME) + ADDR_W'(cnt_q);
      if (!in_range) begin
        over_d = 1'b1;
      end else begin
        unique case (cnt_q)
          LEN_W'(0): type_d        = cmd_i.data;
          LEN_W'(1): src_d[7:0]    = cmd_i.data;
          LEN_W'(2): src_d[15:8]   = cmd_i.data;
          LEN_W'(3): src_d[23:16]  = cmd_i.data;
          LEN_W'(4): seq_d         = cmd_i.data;
          default: ;
        endcase
        mem_we = tv;
        cnt_d  = cnt_q + 1'b1;
      end

      if (cmd_i.last) begin
        p2_valid_d      = 1'b1;
        p2_hit_d        = 1'b0;
        p2_res_d.slot   = '0;
        p2_res_d.length = cnt_d;
        if (over_d) begin
          p2_res_d.status = ST_OVERSIZE;
          p2_res_d.length = LEN_W'(MAX_FRAME);
        end else if (xor_d != 8'h00) begin
          p2_res_d.status = ST_BAD_SUM;
        end else if (type_d == cfg_i.ack_type) begin
          p2_res_d.status = ((src_d == cfg_i.own_id) && (seq_d == cfg_i.exp_seq)) ?
                            ST_ACK_MATCH : ST_ACK_IGNORED;
        end else if (tv) begin
          p2_res_d.status = ST_STORED;
          p2_res_d.slot   = SEL_W'(ts);
          used_d[ts]      = 1'b1;
          len_we          = 1'b1;
        end else begin
          p2_res_d.status = ST_NO_SLOT;
        end
        xor_d       = '0;
        cnt_d       = '0;
        type_d      = '0;
        src_d       = '0;
        seq_d       = '0;
        tgt_valid_d = 1'b0;
        tgt_d       = '0;
        over_d      = 1'b0;
      end
    end

    if (is_release && sel_ok) begin
      used_d[sel_slot] = 1'b0;
    end

    if (is_read) begin
      p2_valid_d      = 1'b1;
      p2_hit_d        = rd_hit;
      p2_res_d.status = ST_READ_DATA;
      p2_res_d.slot   = cmd_i.sel;
      p2_res_d.length = rd_len;
      mem_re          = rd_hit;
      mem_addr        = ADDR_W'(sel_slot) * ADDR_W'(MAX_FRAME) + ADDR_W'(cmd_i.idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= cmd_i.data;
    end
    if (mem_re) begin
      mem_rd_q <= store_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[ts] <= p2_res_d.length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      xor_q       <= '0;
      cnt_q       <= '0;
      type_q      <= '0;
      src_q       <= '0;
      seq_q       <= '0;
      tgt_valid_q <= 1'b0;
      tgt_q       <= '0;
      over_q      <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      xor_q       <= xor_d;
      cnt_q       <= cnt_d;
      type_q      <= type_d;
      src_q       <= src_d;
      seq_q       <= seq_d;
      tgt_valid_q <= tgt_valid_d;
      tgt_q       <= tgt_d;
      over_q      <= over_d;
      p2_valid_q  <= p2_valid_d;
      if (out_load) begin
        out_valid_q <= p2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p2_res_q <= p2_res_d;
    p2_hit_q <= p2_hit_d;
    if (out_load && p2_valid_q) begin
      out_res_q   <= p2_res_q;
      out_rdata_q <= p2_hit_q ? mem_rd_q : 8'h00;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_res_q.status;
  assign out_data_o   = {(OUT_TDATA_W - 8 - LEN_W - SEL_W)'(0), out_rdata_q,
                         out_res_q.length, out_res_q.slot};

endmodule

`default_nettype wire

### design/checksummed_frame_receiver.sv
// Top level of the checksummed frame receiver: configuration registers,
// front end queue and back end. Depends on crx_pkg, crx_front and crx_back.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         tvalid/tready              tdata, tlast, tuser (op)
//   m_axis    out        tvalid/tready              tdata, tuser (status)
//   cfg       in         cfg_we_i, no wait          cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle when the output side keeps up.
// A result passes from the queue to execute, with the frame memory read, and
// then to the output register.
// Reset frees all slots and clears the frame in progress; no clearing pass.
// A stalled output fills the two-entry queue before s_axis_tready drops.
`default_nettype none

module checksummed_frame_receiver (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // tdata: frame_byte[7:0], slot_sel[9:8], byte_index[16:10], zero pad
  input  wire  [crx_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  wire  [crx_pkg::OP_W-1:0]        s_axis_tuser,
  input  wire                             s_axis_tlast,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: slot_out[1:0], frame_length[8:2], read_data[16:9], zero pad
  output logic [crx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [crx_pkg::STATUS_W-1:0]    m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  input  wire                             cfg_we_i,
  input  wire  [crx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [crx_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import crx_pkg::*;

  crx_cfg_t cfg_q;
  crx_cmd_t cmd;
  logic     cmd_valid, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id   <= ID_W'(1);
      cfg_q.exp_seq  <= '0;
      cfg_q.ack_type <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OWN_ID:   cfg_q.own_id   <= cfg_data_i[ID_W-1:0];
        CFG_EXP_SEQ:  cfg_q.exp_seq  <= cfg_data_i[7:0];
        CFG_ACK_TYPE: cfg_q.ack_type <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  crx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_op_i     (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  crx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

### tb/sv/checksummed_frame_receiver_tb.sv
// Self-checking testbench for checksummed_frame_receiver: directed and random words,
// with a predictor of the frame checks and slot store and a scoreboard on each result.
// Depends on crx_pkg and the checksummed_frame_receiver RTL.
`timescale 1ns / 100ps

module checksummed_frame_receiver_tb;
  import crx_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    slot;
    logic [LEN_W-1:0]    length;
    logic [7:0]          data;
  } rx_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // Predictor state: configuration, slot store and the frame in progress.
  logic [23:0]  cfg_own_id;
  logic [7:0]   cfg_exp_seq;
  logic [7:0]   cfg_ack_type;
  logic         slot_busy[SLOTS];
  logic         slot_filled[SLOTS];
  logic [6:0]   slot_len[SLOTS];
  logic [7:0]   slot_bytes[SLOTS][MAX_FRAME];
  logic [7:0]   frame_xor;
  int           frame_count;
  logic [7:0]   hdr_kind;
  logic [23:0]  hdr_src;
  logic [7:0]   hdr_seqno;
  logic         frame_has_slot;
  int           frame_slot;
  logic         frame_over;

  rx_result_t   expected_responses[$];
  int           fail_count = 0;
  int           words_sent = 0;
  int           send_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           rx_hold_left = 0;
  logic         out_fire;
  rx_result_t   out_seen;

  checksummed_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void clear_frame();
    frame_xor      = '0;
    frame_count    = 0;
    hdr_kind       = '0;
    hdr_src        = '0;
    hdr_seqno      = '0;
    frame_has_slot = 1'b0;
    frame_slot     = 0;
    frame_over     = 1'b0;
  endfunction

  // Works out the response to one accepted word and queues it, if there is one.
  function automatic void compute_response(input logic [OP_W-1:0] op, input logic [7:0] b,
                                           input logic last, input logic [SEL_W-1:0] sel,
                                           input logic [IDX_W-1:0] idx);
    rx_result_t r;
    int s;
    r = '0;
    case (op)
      OP_BYTE: begin
        if (frame_count == 0 && !frame_over) begin
          for (s = 0; s < SLOTS; s++) begin
            if (!slot_busy[s] && !frame_has_slot) begin
              frame_has_slot = 1'b1;
              frame_slot = s;
            end
          end
        end
        frame_xor ^= b;
        if (frame_count >= MAX_FRAME) begin
          frame_over = 1'b1;
        end else begin
          if (frame_count == 0) hdr_kind = b;
          else if (frame_count <= 3) hdr_src[8*(frame_count-1) +: 8] = b;
          else if (frame_count == 4) hdr_seqno = b;
          if (frame_has_slot) slot_bytes[frame_slot][frame_count] = b;
          frame_count++;
        end
        if (last) begin
          r.length = 7'(frame_count);
          if (frame_over) begin
            r.status = ST_OVERSIZE;
            r.length = 7'(MAX_FRAME);
          end else if (frame_xor != 8'h00) begin
            r.status = ST_BAD_SUM;
          end else if (hdr_kind == cfg_ack_type) begin
            r.status = (hdr_src == cfg_own_id && hdr_seqno == cfg_exp_seq) ?
                       ST_ACK_MATCH : ST_ACK_IGNORED;
          end else if (frame_has_slot) begin
            slot_busy[frame_slot]   = 1'b1;
            slot_filled[frame_slot] = 1'b1;
            slot_len[frame_slot]    = 7'(frame_count);
            r.status = ST_STORED;
            r.slot   = 2'(frame_slot);
          end else begin
            r.status = ST_NO_SLOT;
          end
          expected_responses.push_back(r);
          clear_frame();
        end
      end
      OP_RELEASE: begin
        slot_busy[sel] = 1'b0;
      end
      OP_READ: begin
        r.status = ST_READ_DATA;
        r.slot   = sel;
        r.length = slot_len[sel];
        if (idx < slot_len[sel] && idx < MAX_FRAME) r.data = slot_bytes[sel][idx];
        expected_responses.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input rx_result_t want,
                                 input rx_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected status %0d slot %0d length %0d data %02h",
               $realtime, what, want.status, want.slot, want.length, want.data);
      $display("  got status %0d slot %0d length %0d data %02h",
               got.status, got.slot, got.length, got.data);
    end
  endtask

  // Output side: sample at the falling edge, check and drive tready at the rising edge.
  always @(negedge clk_i) begin
    out_fire        = rst_ni && m_axis_tvalid && m_axis_tready;
    out_seen.status = m_axis_tuser;
    out_seen.slot   = m_axis_tdata[1:0];
    out_seen.length = m_axis_tdata[8:2];
    out_seen.data   = m_axis_tdata[16:9];
  end

  always @(posedge clk_i) begin
    if (out_fire) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected result", '0, out_seen);
      end else if (expected_responses[0] != out_seen) begin
        report_mismatch("result mismatch", expected_responses[0], out_seen);
        void'(expected_responses.pop_front());
      end else begin
        void'(expected_responses.pop_front());
      end
    end
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] b, input logic last,
                           input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {7'b0, idx, sel, b};
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    words_sent++;
    compute_response(op, b, last, sel, idx);
  endtask

  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OWN_ID:   cfg_own_id   = value;
      CFG_EXP_SEQ:  cfg_exp_seq  = value[7:0];
      CFG_ACK_TYPE: cfg_ack_type = value[7:0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  function automatic int pick_filled_slot();
    int cand[$];
    int s;
    for (s = 0; s < SLOTS; s++) if (slot_filled[s]) cand.push_back(s);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  // Reads only slots that have stored a frame, so no unwritten entry is ever read.
  task automatic random_read();
    int s;
    logic [IDX_W-1:0] idx;
    s = pick_filled_slot();
    if (s >= 0) begin
      if ($urandom_range(99) < 70) idx = 7'($urandom_range(int'(slot_len[s]) - 1));
      else idx = 7'($urandom);
      send_word(OP_READ, 8'($urandom), 1'($urandom), 2'(s), idx);
    end
  endtask

  function automatic byte_q_t make_frame(input int n, input logic [7:0] kind,
                                         input logic [23:0] src, input logic [7:0] seq,
                                         input bit good);
    byte_q_t fb;
    logic [7:0] sum;
    int i;
    sum = 8'h00;
    for (i = 0; i < n - 1; i++) begin
      if (i == 0) fb.push_back(kind);
      else if (i <= 3) fb.push_back(src[8*(i-1) +: 8]);
      else if (i == 4) fb.push_back(seq);
      else fb.push_back(8'($urandom));
      sum ^= fb[i];
    end
    if (!good) sum ^= 8'($urandom_range(255, 1));
    fb.push_back(sum);
    return fb;
  endfunction

  task automatic send_frame(input byte_q_t fb, input int interleave_pct);
    int i;
    for (i = 0; i < fb.size(); i++) begin
      if ($urandom_range(99) < interleave_pct) begin
        if ($urandom_range(1)) random_read();
        else send_word(OP_RELEASE, 8'($urandom), 1'($urandom), 2'($urandom), 7'($urandom));
      end
      send_word(OP_BYTE, fb[i], i == fb.size() - 1, 2'($urandom), 7'($urandom));
    end
  endtask

  task automatic release_all();
    int s;
    for (s = 0; s < SLOTS; s++) send_word(OP_RELEASE, 8'h00, 1'b0, 2'(s), 7'd0);
  endtask

  // Runs at the reset configuration: own id 1, sequence 0, acknowledge type 0.
  task automatic test_basic_frames();
    send_word(OP_BYTE, 8'h00, 1'b1, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'hFF, 1'b1, 2'd3, 7'd127);
    send_word(OP_BYTE, 8'h00, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h01, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h00, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h00, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h00, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h01, 1'b1, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h5A, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h5A, 1'b1, 2'd0, 7'd0);
    send_word(OP_READ, 8'h00, 1'b0, 2'd0, 7'd0);
    send_word(OP_READ, 8'hFF, 1'b1, 2'd0, 7'd1);
    send_word(OP_READ, 8'h00, 1'b0, 2'd0, 7'd127);
    send_word(OP_BYTE, 8'hFF, 1'b0, 2'd3, 7'd127);
    send_word(OP_BYTE, 8'h80, 1'b0, 2'd0, 7'd0);
    send_word(OP_BYTE, 8'h7F, 1'b1, 2'd0, 7'd0);
    send_word(OP_RELEASE, 8'h00, 1'b0, 2'd0, 7'd0);
    send_word(OP_READ, 8'h00, 1'b0, 2'd0, 7'd1);
    send_word(OP_READ, 8'h00, 1'b0, 2'd1, 7'd2);
    send_word(OP_UNUSED, 8'hFF, 1'b1, 2'd3, 7'd127);
    await_idle();
  endtask

  task automatic test_slot_exhaustion();
    byte_q_t fb;
    int i;
    int n;
    release_all();
    for (n = 0; n < SLOTS + 1; n++) send_frame(make_frame(3, 8'h33, 24'h0, 8'h0, 1'b1), 0);
    fb = make_frame(4, 8'h34, 24'h0, 8'h0, 1'b1);
    for (i = 0; i < fb.size(); i++) begin
      if (i == 2) send_word(OP_RELEASE, 8'h00, 1'b0, 2'd1, 7'd0);
      send_word(OP_BYTE, fb[i], i == fb.size() - 1, 2'd0, 7'd0);
    end
    // Slot 1 is free at frame start; releasing it again mid-frame keeps it as target.
    fb = make_frame(4, 8'h35, 24'h0, 8'h0, 1'b1);
    for (i = 0; i < fb.size(); i++) begin
      if (i == 1) send_word(OP_RELEASE, 8'h00, 1'b0, 2'd1, 7'd0);
      send_word(OP_BYTE, fb[i], i == fb.size() - 1, 2'd0, 7'd0);
    end
    send_word(OP_READ, 8'h00, 1'b0, 2'd1, 7'd3);
    send_word(OP_READ, 8'h00, 1'b0, 2'd1, 7'd4);
    await_idle();
  endtask

  task automatic test_oversize();
    release_all();
    send_frame(make_frame(MAX_FRAME, 8'h44, 24'h123456, 8'h9A, 1'b1), 0);
    send_word(OP_READ, 8'h00, 1'b0, 2'd0, 7'(MAX_FRAME - 1));
    send_word(OP_READ, 8'h00, 1'b0, 2'd0, 7'(MAX_FRAME));
    send_word(OP_READ, 8'h00, 1'b0, 2'd0, 7'd127);
    send_frame(make_frame(MAX_FRAME + 1, 8'h45, 24'h0, 8'h0, 1'b1), 0);
    send_frame(make_frame(MAX_FRAME + 9, 8'h46, 24'h0, 8'h0, 1'b0), 0);
    send_word(OP_READ, 8'h00, 1'b0, 2'd1, 7'd10);
    await_idle();
  endtask

  // The output holds off for a long stretch while single-byte frames keep coming.
  task automatic test_output_backpressure();
    int n;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    rx_hold_left  = 300;
    for (n = 0; n < 40; n++) send_word(OP_BYTE, 8'($urandom_range(3)), 1'b1, 2'd0, 7'd0);
    await_idle();
  endtask

  task automatic send_random_frame();
    int pick;
    int n;
    logic [7:0] kind;
    logic [23:0] src;
    logic [7:0] seq;
    pick = $urandom_range(99);
    if (pick < 70) n = $urandom_range(16, 1);
    else if (pick < 90) n = $urandom_range(MAX_FRAME, 17);
    else if (pick < 97) n = $urandom_range(MAX_FRAME, MAX_FRAME - 2);
    else n = $urandom_range(MAX_FRAME + 14, MAX_FRAME + 1);
    kind = ($urandom_range(99) < 35) ? cfg_ack_type : 8'($urandom);
    src  = ($urandom_range(99) < 50) ? cfg_own_id : 24'($urandom);
    seq  = ($urandom_range(99) < 60) ? cfg_exp_seq : 8'($urandom);
    send_frame(make_frame(n, kind, src, seq, $urandom_range(99) < 85), 4);
  endtask

  task automatic test_random_phase(input logic [23:0] own_id, input logic [7:0] exp_seq,
                                   input logic [7:0] ack_type, input int idle_pct,
                                   input int stall_pct, input int quota);
    int first;
    int pick;
    await_idle();
    write_reg(CFG_OWN_ID, own_id);
    write_reg(CFG_EXP_SEQ, {16'h0, exp_seq});
    write_reg(CFG_ACK_TYPE, {16'h0, ack_type});
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    first = words_sent;
    while (words_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 60) send_random_frame();
      else if (pick < 82) random_read();
      else if (pick < 93)
        send_word(OP_RELEASE, 8'($urandom), 1'($urandom), 2'($urandom), 7'($urandom));
      else if (pick < 95)
        send_word(OP_UNUSED, 8'($urandom), 1'($urandom), 2'($urandom), 7'($urandom));
      else
        send_word(OP_BYTE, 8'($urandom), 1'($urandom), 2'($urandom), 7'($urandom));
    end
    await_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    cfg_own_id    = 24'd1;
    cfg_exp_seq   = 8'd0;
    cfg_ack_type  = 8'd0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_busy[s]   = 1'b0;
      slot_filled[s] = 1'b0;
      slot_len[s]    = '0;
      for (int i = 0; i < MAX_FRAME; i++) slot_bytes[s][i] = '0;
    end
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frames();
    test_slot_exhaustion();
    test_oversize();
    test_output_backpressure();
    test_random_phase(24'hFFFFFF, 8'hFF, 8'hFF, 0, 0, 260);
    test_random_phase(24'h000000, 8'h00, 8'h00, 87, 0, 260);
    test_random_phase(24'($urandom), 8'($urandom), 8'($urandom), 0, 87, 260);
    test_random_phase(24'($urandom), 8'($urandom), 8'($urandom), 18, 18, 260);

    rx_stall_pct = 0;
    await_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_responses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
